@@ hw/rtl/dszm_pkg.sv @@
`default_nettype none

package dszm_pkg;

   // field and register widths
   localparam int CMD_W   = 3;
   localparam int PRESS_W = 20;
   localparam int TEMP_W  = 15;
   localparam int FAULT_W = 8;
   localparam int SCALE_W = 20;
   localparam int DEPTH_W = 25;
   localparam int LEVEL_W = 21;
   localparam int COUNT_W = 6;
   localparam int DIFF_W  = LEVEL_W + 1;

   // stream payload widths (the tdata widths are whole bytes)
   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = CMD_W;
   localparam int RSP_DATA_W = 48;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = SCALE_W;

   // zeroing schedule defaults
   localparam int DISCARD_SAMPLES_DEF  = 20;
   localparam int LAST_ZERO_SAMPLE_DEF = 40;

   // register reset values
   localparam logic [FAULT_W-1:0] FAULT_COUNT_RST = 8'd3;
   localparam logic [SCALE_W-1:0] DEPTH_SCALE_RST = 20'd670293;

   // depth scale is Q16
   localparam int SCALE_FRAC = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_SAMPLE    = 3'd0,
      CMD_COMM_FAIL = 3'd1,
      CMD_POLL      = 3'd2,
      CMD_RECAL     = 3'd3,
      CMD_INIT_DONE = 3'd4,
      CMD_FATAL     = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_UNINIT  = 2'd0,
      MODE_ZEROING = 2'd1,
      MODE_RUNNING = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_COMM     = 2'd1,
      ERR_OVERRUN  = 2'd2,
      ERR_FATAL    = 2'd3
   } err_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FAULT_COUNT = 1'b0,
      CSR_DEPTH_SCALE = 1'b1
   } csr_type;

   // status flags reported with every result
   typedef struct packed {
      logic    reading_valid;
      logic    zeroing;
      err_type error_event;
      logic    error_recoverable;
      logic    new_reading;
   } status_type;

   // handoff from the state update stage to the depth stage
   typedef struct packed {
      logic [DIFF_W-1:0] diff;
      logic [TEMP_W-1:0] temperature;
      status_type        status;
   } mid_type;

endpackage

`default_nettype wire

@@ hw/rtl/dszm_state.sv @@
`default_nettype none

module dszm_state #(
   parameter int DISCARD_SAMPLES  = dszm_pkg::DISCARD_SAMPLES_DEF,
   parameter int LAST_ZERO_SAMPLE = dszm_pkg::LAST_ZERO_SAMPLE_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               in_vld,
   output logic                              in_rdy,
   input  dszm_pkg::cmd_type                 cmd,
   input  wire  [dszm_pkg::PRESS_W-1:0]      pressure,
   input  wire  [dszm_pkg::TEMP_W-1:0]       temperature,
   input  wire                               sensor_busy,
   input  wire  [dszm_pkg::FAULT_W-1:0]      fault_count,
   output logic                              mid_vld,
   input  wire                               mid_rdy,
   output dszm_pkg::mid_type                 mid
);

   localparam int CNT1_W = dszm_pkg::COUNT_W + 1;
   localparam int BLEND_W = 25;
   localparam int RECIP_W = 32;
   localparam int RECIP_SHIFT = 35;
   localparam int PROD_W = BLEND_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;
   localparam logic [CNT1_W-1:0] SEED_N = CNT1_W'(DISCARD_SAMPLES + 1);
   localparam logic [CNT1_W-1:0] LAST_N = CNT1_W'(LAST_ZERO_SAMPLE);
   localparam logic [dszm_pkg::FAULT_W-1:0] SAT_MAX = '1;

   dszm_pkg::mode_type               mode_ff, mode_in;
   logic [dszm_pkg::COUNT_W-1:0]     zcnt_ff, zcnt_in;
   logic [dszm_pkg::LEVEL_W-1:0]     level_ff, level_in;
   logic [dszm_pkg::LEVEL_W-1:0]     lastp_ff, lastp_in;
   logic [dszm_pkg::TEMP_W-1:0]      lastt_ff, lastt_in;
   logic [dszm_pkg::FAULT_W-1:0]     bad_ff, bad_in;
   logic [dszm_pkg::FAULT_W-1:0]     age_ff, age_in;
   logic                             recal_ff, recal_in;
   logic                             seen_ff, seen_in;
   dszm_pkg::err_type                err;
   logic                             recov;

   logic                             mid_vld_ff;
   dszm_pkg::mid_type                mid_ff, mid_in;

   logic                             in_fire;
   logic [CNT1_W-1:0]                zcnt_inc;
   logic [BLEND_W-1:0]               blend;
   logic [PROD_W-1:0]                blend_prod;
   logic [dszm_pkg::LEVEL_W-1:0]     blend_div;

   assign in_rdy  = !mid_vld_ff || mid_rdy;
   assign in_fire = in_vld && in_rdy;

   // surface filter: (7*s + 3*p) / 10 via exact reciprocal multiply
   assign zcnt_inc   = {1'b0, zcnt_ff} + CNT1_W'(1);
   assign blend      = BLEND_W'(level_ff) * BLEND_W'(7) + BLEND_W'(pressure) * BLEND_W'(3);
   assign blend_prod = PROD_W'(blend) * PROD_W'(RECIP_TEN);
   assign blend_div  = blend_prod[RECIP_SHIFT +: dszm_pkg::LEVEL_W];

   // next state for one event
   always_comb begin
      mode_in  = mode_ff;
      zcnt_in  = zcnt_ff;
      level_in = level_ff;
      lastp_in = lastp_ff;
      lastt_in = lastt_ff;
      bad_in   = bad_ff;
      age_in   = age_ff;
      recal_in = recal_ff;
      seen_in  = seen_ff;
      err      = dszm_pkg::ERR_NONE;
      recov    = 1'b0;
      case (cmd)
         dszm_pkg::CMD_SAMPLE: begin
            if (mode_ff == dszm_pkg::MODE_ZEROING) begin
               zcnt_in = zcnt_inc[dszm_pkg::COUNT_W-1:0];
               if (zcnt_inc <= LAST_N) begin
                  if (zcnt_inc == SEED_N) begin
                     level_in = dszm_pkg::LEVEL_W'(pressure);
                  end else if (zcnt_inc > SEED_N) begin
                     level_in = blend_div;
                  end
               end else begin
                  mode_in = dszm_pkg::MODE_RUNNING;
               end
            end else if (mode_ff == dszm_pkg::MODE_RUNNING) begin
               lastp_in = dszm_pkg::LEVEL_W'(pressure);
               lastt_in = temperature;
               age_in   = '0;
               bad_in   = '0;
               seen_in  = 1'b1;
            end
         end
         dszm_pkg::CMD_COMM_FAIL: begin
            if (mode_ff == dszm_pkg::MODE_ZEROING) begin
               // losing the sensor mid-calibration is not recoverable
               mode_in = dszm_pkg::MODE_UNINIT;
               err     = dszm_pkg::ERR_COMM;
            end else if (mode_ff == dszm_pkg::MODE_RUNNING) begin
               bad_in = (bad_ff != SAT_MAX) ? bad_ff + 1'b1 : bad_ff;
               if (bad_in >= fault_count) begin
                  err   = dszm_pkg::ERR_COMM;
                  recov = 1'b1;
               end
            end
         end
         dszm_pkg::CMD_POLL: begin
            if (mode_ff == dszm_pkg::MODE_RUNNING) begin
               age_in = (age_ff != SAT_MAX) ? age_ff + 1'b1 : age_ff;
               if (sensor_busy) begin
                  err   = dszm_pkg::ERR_OVERRUN;
                  recov = 1'b1;
               end else if (recal_ff) begin
                  recal_in = 1'b0;
                  age_in   = fault_count;
                  zcnt_in  = '0;
                  mode_in  = dszm_pkg::MODE_ZEROING;
               end
            end
         end
         dszm_pkg::CMD_RECAL: begin
            recal_in = 1'b1;
         end
         dszm_pkg::CMD_INIT_DONE: begin
            mode_in = dszm_pkg::MODE_ZEROING;
            zcnt_in = '0;
         end
         dszm_pkg::CMD_FATAL: begin
            mode_in = dszm_pkg::MODE_UNINIT;
            err     = dszm_pkg::ERR_FATAL;
         end
         default: begin
         end
      endcase

      // result fields from the updated state
      mid_in.diff        = {1'b0, lastp_in} - {1'b0, level_in};
      mid_in.temperature = lastt_in;
      mid_in.status.reading_valid     = (mode_in == dszm_pkg::MODE_RUNNING) &&
                                        (age_in < fault_count);
      mid_in.status.zeroing           = (mode_in == dszm_pkg::MODE_ZEROING);
      mid_in.status.error_event       = err;
      mid_in.status.error_recoverable = recov;
      mid_in.status.new_reading       = seen_in;
   end

   // state registers, updated once per accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= dszm_pkg::MODE_UNINIT;
         zcnt_ff  <= '0;
         level_ff <= '0;
         lastp_ff <= '0;
         lastt_ff <= '0;
         bad_ff   <= '0;
         age_ff   <= dszm_pkg::FAULT_COUNT_RST;
         recal_ff <= 1'b0;
         seen_ff  <= 1'b0;
      end else if (in_fire) begin
         mode_ff  <= mode_in;
         zcnt_ff  <= zcnt_in;
         level_ff <= level_in;
         lastp_ff <= lastp_in;
         lastt_ff <= lastt_in;
         bad_ff   <= bad_in;
         age_ff   <= age_in;
         recal_ff <= recal_in;
         seen_ff  <= seen_in;
      end
   end

   // handoff register toward the depth stage
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_vld_ff <= 1'b0;
      end else if (in_rdy) begin
         mid_vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         mid_ff <= mid_in;
      end
   end

   assign mid_vld = mid_vld_ff;
   assign mid     = mid_ff;

   // recoverable flag only rides on a real error
   a_recov_has_err: assert property (@(posedge clock) disable iff (reset)
      mid_vld_ff && mid_ff.status.error_recoverable |->
         mid_ff.status.error_event != dszm_pkg::ERR_NONE)
      else $error("recoverable flag without error");

   // a reading is never valid while zeroing
   a_valid_not_zeroing: assert property (@(posedge clock) disable iff (reset)
      mid_vld_ff |-> !(mid_ff.status.zeroing && mid_ff.status.reading_valid))
      else $error("valid reading during zeroing");

   // fatal fault always drops to uninitialized
   a_fatal_uninit: assert property (@(posedge clock) disable iff (reset)
      in_fire && cmd == dszm_pkg::CMD_FATAL |=> mode_ff == dszm_pkg::MODE_UNINIT)
      else $error("fatal fault did not deinitialize");

   // init done restarts zeroing from the first sample
   a_init_restart: assert property (@(posedge clock) disable iff (reset)
      in_fire && cmd == dszm_pkg::CMD_INIT_DONE |=>
         mode_ff == dszm_pkg::MODE_ZEROING && zcnt_ff == '0)
      else $error("init done did not restart zeroing");

   // a stalled handoff keeps its contents
   a_mid_hold: assert property (@(posedge clock) disable iff (reset)
      mid_vld_ff && !mid_rdy |=> mid_vld_ff && $stable(mid_ff))
      else $error("handoff register changed while stalled");

endmodule

`default_nettype wire

@@ hw/rtl/dszm_depth.sv @@
`default_nettype none

module dszm_depth (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               mid_vld,
   output logic                              mid_rdy,
   input  dszm_pkg::mid_type                 mid,
   input  wire  [dszm_pkg::SCALE_W-1:0]      depth_scale,
   output logic                              rsp_vld,
   input  wire                               rsp_rdy,
   output logic [dszm_pkg::RSP_DATA_W-1:0]   rsp_data
);

   localparam int PROD_W = dszm_pkg::DIFF_W + dszm_pkg::SCALE_W + 1;
   localparam int PAD_W  = dszm_pkg::RSP_DATA_W - dszm_pkg::DEPTH_W - dszm_pkg::TEMP_W - 6;

   logic signed [PROD_W-1:0]          prod;
   logic [dszm_pkg::DEPTH_W-1:0]      depth_in;

   logic                              rsp_vld_ff;
   logic [dszm_pkg::DEPTH_W-1:0]      depth_ff;
   logic [dszm_pkg::TEMP_W-1:0]       temp_ff;
   dszm_pkg::status_type              status_ff;

   // signed pressure offset times Q16 scale, floor by arithmetic shift
   assign prod     = PROD_W'($signed(mid.diff)) *
                     PROD_W'($signed({1'b0, depth_scale}));
   assign depth_in = prod[dszm_pkg::SCALE_FRAC +: dszm_pkg::DEPTH_W];

   assign mid_rdy = !rsp_vld_ff || rsp_rdy;

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (mid_rdy) begin
         rsp_vld_ff <= mid_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_rdy && mid_vld) begin
         depth_ff  <= depth_in;
         temp_ff   <= mid.temperature;
         status_ff <= mid.status;
      end
   end

   assign rsp_vld  = rsp_vld_ff;
   assign rsp_data = {{PAD_W{1'b0}},
                      status_ff.new_reading,
                      status_ff.error_recoverable,
                      status_ff.error_event,
                      status_ff.zeroing,
                      status_ff.reading_valid,
                      temp_ff,
                      depth_ff};

endmodule

`default_nettype wire

@@ hw/rtl/depth_sensor_zero_and_monitor.sv @@
`default_nettype none

// Channel  Dir  Ports                                 Contents
// req      in   req_tvalid/req_tready/req_tdata/      one sensor event
//               req_tuser
// rsp      out  rsp_tvalid/rsp_tready/rsp_tdata       depth, temperature, status
// csr      in   csr_we/csr_index/csr_wdata            fault_count, depth_scale
//
// One event per clock while the result side keeps up. The state update
// (including the surface filter's reciprocal multiply) settles in the
// accept cycle into the handoff register; the depth multiply sits in the
// following stage and feeds the result register behind rsp_tvalid.
// Synchronous reset clears mode, the zeroing and bad-read counters and
// both valid stages. With rsp_tready low, the result and handoff registers
// hold up to two transactions; req_tready drops once both are full.

module depth_sensor_zero_and_monitor #(
   parameter int DISCARD_SAMPLES  = dszm_pkg::DISCARD_SAMPLES_DEF,
   parameter int LAST_ZERO_SAMPLE = dszm_pkg::LAST_ZERO_SAMPLE_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // [19:0] pressure, [34:20] temperature, [35] sensor_busy
   input  wire  [dszm_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [2:0] command
   input  wire  [dszm_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // [24:0] depth_mm, [39:25] temperature_out, [40] reading_valid,
   // [41] zeroing, [43:42] error_event, [44] error_recoverable,
   // [45] new_reading
   output logic [dszm_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  wire                                csr_we,
   input  wire  [dszm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [dszm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int TEMP_LO = dszm_pkg::PRESS_W;
   localparam int BUSY_BIT = dszm_pkg::PRESS_W + dszm_pkg::TEMP_W;

   logic [dszm_pkg::FAULT_W-1:0]  fault_count_ff;
   logic [dszm_pkg::SCALE_W-1:0]  depth_scale_ff;

   logic                          mid_vld;
   logic                          mid_rdy;
   dszm_pkg::mid_type             mid;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fault_count_ff <= dszm_pkg::FAULT_COUNT_RST;
         depth_scale_ff <= dszm_pkg::DEPTH_SCALE_RST;
      end else if (csr_we) begin
         case (dszm_pkg::csr_type'(csr_index))
            dszm_pkg::CSR_FAULT_COUNT: fault_count_ff <= csr_wdata[dszm_pkg::FAULT_W-1:0];
            dszm_pkg::CSR_DEPTH_SCALE: depth_scale_ff <= csr_wdata[dszm_pkg::SCALE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // event decode and state update
   dszm_state #(
      .DISCARD_SAMPLES  (DISCARD_SAMPLES),
      .LAST_ZERO_SAMPLE (LAST_ZERO_SAMPLE)
   ) u_state (
      .clock       (clock),
      .reset       (reset),
      .in_vld      (req_tvalid),
      .in_rdy      (req_tready),
      .cmd         (dszm_pkg::cmd_type'(req_tuser)),
      .pressure    (req_tdata[dszm_pkg::PRESS_W-1:0]),
      .temperature (req_tdata[TEMP_LO +: dszm_pkg::TEMP_W]),
      .sensor_busy (req_tdata[BUSY_BIT]),
      .fault_count (fault_count_ff),
      .mid_vld     (mid_vld),
      .mid_rdy     (mid_rdy),
      .mid         (mid)
   );

   // depth scaling and result register
   dszm_depth u_depth (
      .clock       (clock),
      .reset       (reset),
      .mid_vld     (mid_vld),
      .mid_rdy     (mid_rdy),
      .mid         (mid),
      .depth_scale (depth_scale_ff),
      .rsp_vld     (rsp_tvalid),
      .rsp_rdy     (rsp_tready),
      .rsp_data    (rsp_tdata)
   );

endmodule

`default_nettype wire

@@ tb/depth_sensor_zero_and_monitor_test.sv @@
`timescale 1ns / 100ps

import dszm_pkg::*;

// one expected result, with the fields of rsp_tdata
typedef struct {
   logic [DEPTH_W-1:0] depth_mm;
   logic [TEMP_W-1:0]  temperature;
   logic               reading_valid;
   logic               zeroing;
   err_type            error_event;
   logic               error_recoverable;
   logic               new_reading;
} reading_type;

// Depth monitor predictor and result checker
class depth_scoreboard;
   // register copies
   logic [FAULT_W-1:0] fault_count;
   logic [SCALE_W-1:0] depth_scale;
   // block state
   mode_type           mode;
   logic [COUNT_W-1:0] zero_samples;
   logic [LEVEL_W-1:0] surface_level;
   logic [LEVEL_W-1:0] last_pressure;
   logic [TEMP_W-1:0]  last_temp;
   logic [7:0]         bad_reads;
   logic [7:0]         reading_age;
   bit                 recal_pending;
   bit                 read_seen;

   reading_type        expected_q[$];
   int unsigned        errors;
   int unsigned        checked;
   int unsigned        events;
   int unsigned        useful_events;
   int unsigned        stored;
   int unsigned        err_seen[4];

   function new();
      fault_count   = FAULT_COUNT_RST;
      depth_scale   = DEPTH_SCALE_RST;
      mode          = MODE_UNINIT;
      zero_samples  = '0;
      surface_level = '0;
      last_pressure = '0;
      last_temp     = '0;
      bad_reads     = '0;
      reading_age   = FAULT_COUNT_RST;
      recal_pending = 1'b0;
      read_seen     = 1'b0;
   endfunction

   function void set_register(csr_type idx, logic [CSR_DATA_W-1:0] value);
      if (idx == CSR_FAULT_COUNT)
         fault_count = value[FAULT_W-1:0];
      else
         depth_scale = value;
   endfunction

   // apply one accepted event and queue the result it must produce
   function void note_event(logic [CMD_W-1:0] cmd, logic [PRESS_W-1:0] pressure,
                            logic [TEMP_W-1:0] temp, logic busy);
      reading_type r;
      int unsigned n;
      longint      prod;
      err_type     err;
      logic        recov;
      err   = ERR_NONE;
      recov = 1'b0;
      events++;
      if (mode != MODE_UNINIT || cmd == CMD_RECAL || cmd == CMD_INIT_DONE || cmd == CMD_FATAL)
         useful_events++;

      case (cmd)
         CMD_SAMPLE: begin
            if (mode == MODE_ZEROING) begin
               n = zero_samples + 1;
               zero_samples = COUNT_W'(n);
               if (n <= LAST_ZERO_SAMPLE_DEF) begin
                  if (n == DISCARD_SAMPLES_DEF + 1)
                     surface_level = LEVEL_W'(pressure);
                  else if (n > DISCARD_SAMPLES_DEF + 1)
                     surface_level = LEVEL_W'((7 * longint'(surface_level)
                                               + 3 * longint'(pressure)) / 10);
               end else begin
                  mode = MODE_RUNNING;
               end
            end else if (mode == MODE_RUNNING) begin
               last_pressure = LEVEL_W'(pressure);
               last_temp     = temp;
               reading_age   = '0;
               bad_reads     = '0;
               read_seen     = 1'b1;
               stored++;
            end
         end
         CMD_COMM_FAIL: begin
            if (mode == MODE_ZEROING) begin
               // losing the sensor mid-calibration is not recoverable
               mode = MODE_UNINIT;
               err  = ERR_COMM;
            end else if (mode == MODE_RUNNING) begin
               if (bad_reads < 8'd255)
                  bad_reads++;
               if (bad_reads >= fault_count) begin
                  err   = ERR_COMM;
                  recov = 1'b1;
               end
            end
         end
         CMD_POLL: begin
            if (mode == MODE_RUNNING) begin
               if (reading_age < 8'd255)
                  reading_age++;
               if (busy) begin
                  err   = ERR_OVERRUN;
                  recov = 1'b1;
               end else if (recal_pending) begin
                  recal_pending = 1'b0;
                  reading_age   = fault_count;
                  zero_samples  = '0;
                  mode          = MODE_ZEROING;
               end
            end
         end
         CMD_RECAL: recal_pending = 1'b1;
         CMD_INIT_DONE: begin
            mode         = MODE_ZEROING;
            zero_samples = '0;
         end
         CMD_FATAL: begin
            mode = MODE_UNINIT;
            err  = ERR_FATAL;
         end
         default: ;
      endcase
      err_seen[err]++;

      // Q16 scale, floor toward minus infinity
      prod = (longint'(last_pressure) - longint'(surface_level)) * longint'(depth_scale);
      r.depth_mm          = DEPTH_W'(prod >>> SCALE_FRAC);
      r.temperature       = last_temp;
      r.reading_valid     = (mode == MODE_RUNNING) && (reading_age < fault_count);
      r.zeroing           = (mode == MODE_ZEROING);
      r.error_event       = err;
      r.error_recoverable = recov;
      r.new_reading       = read_seen;
      expected_q.push_back(r);
   endfunction

   task report_mismatch(string what, longint got, longint want);
      errors++;
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   task check_field(string what, longint got, longint want);
      if (got != want)
         report_mismatch(what, got, want);
   endtask

   // compare one accepted result with the oldest expectation
   task check_result(logic [RSP_DATA_W-1:0] d);
      reading_type r;
      if (expected_q.size() == 0) begin
         report_mismatch("result with no event waiting", d, 0);
         return;
      end
      r = expected_q.pop_front();
      checked++;
      check_field("depth_mm", d[24:0], r.depth_mm);
      check_field("temperature_out", d[39:25], r.temperature);
      check_field("reading_valid", d[40], r.reading_valid);
      check_field("zeroing", d[41], r.zeroing);
      check_field("error_event", d[43:42], r.error_event);
      check_field("error_recoverable", d[44], r.error_recoverable);
      check_field("new_reading", d[45], r.new_reading);
   endtask
endclass

module depth_sensor_zero_and_monitor_test;

   localparam int NUM_PHASES   = 6;
   localparam int RANDOM_ITEMS = 1550;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   depth_scoreboard sb = new();

   // idling odds: 0 means none, else one chance in N per slot
   int unsigned req_gap_odds   = 0;
   int unsigned rsp_stall_odds = 0;
   int unsigned press_base     = 100000;

   depth_sensor_zero_and_monitor i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // sample both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata);
         if (req_tvalid && req_tready)
            sb.note_event(req_tuser, req_tdata[19:0], req_tdata[34:20], req_tdata[35]);
      end
   end

   // result side stalls in random-length bursts
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_stall_odds != 0 && $urandom_range(1, rsp_stall_odds) == 1) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(0, 14)) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   task automatic idle_req(int unsigned cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         req_tuser  = REQ_USER_W'($urandom);
      end
   endtask

   // one sensor event transaction
   task automatic send_event(logic [CMD_W-1:0] cmd, logic [PRESS_W-1:0] pressure,
                             logic [TEMP_W-1:0] temp, logic busy);
      if (req_gap_odds != 0 && $urandom_range(1, req_gap_odds) == 1)
         idle_req($urandom_range(1, 15));
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = {4'b0, busy, temp, pressure};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   task automatic hold_until_drained();
      idle_req(1);
      while (sb.expected_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(csr_type idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      req_tvalid = 1'b0;
      csr_we     = 1'b1;
      csr_index  = idx;
      csr_wdata  = value;
      sb.set_register(idx, value);
      @(negedge clock);
      csr_we     = 1'b0;
   endtask

   function automatic logic [PRESS_W-1:0] rand_pressure();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return PRESS_W'($urandom);
         default: return PRESS_W'(press_base + $urandom_range(0, 40000));
      endcase
   endfunction

   function automatic logic [TEMP_W-1:0] rand_temp();
      case ($urandom_range(0, 7))
         0: return 15'h4000;
         1: return 15'h3FFF;
         2: return TEMP_W'($urandom);
         default: return TEMP_W'($urandom_range(0, 12500) - 4000);
      endcase
   endfunction

   task automatic send_random(logic [CMD_W-1:0] cmd);
      send_event(cmd, rand_pressure(), rand_temp(), 1'($urandom));
   endtask

   // one event of a running-mode mix
   task automatic send_running_item();
      int unsigned k;
      k = $urandom_range(0, 99);
      if ($urandom_range(0, 499) == 0) begin
         // long bursts of comm failures and busy polls drive up the bad-read and age counters
         repeat ($urandom_range(256, 270))
            send_event($urandom_range(0, 1) ? CMD_COMM_FAIL : CMD_POLL,
                       rand_pressure(), rand_temp(), 1'b1);
      end else if (k < 38) begin
         send_random(CMD_SAMPLE);
      end else if (k < 68) begin
         send_event(CMD_POLL, rand_pressure(), rand_temp(), $urandom_range(0, 3) == 0);
      end else if (k < 84) begin
         send_random(CMD_COMM_FAIL);
      end else if (k < 87) begin
         repeat ($urandom_range(1, 20)) send_random(CMD_COMM_FAIL);
      end else if (k < 89) begin
         repeat ($urandom_range(1, 20)) send_random(CMD_POLL);
      end else if (k < 93) begin
         send_random(CMD_RECAL);
      end else if (k < 96) begin
         send_random(CMD_W'($urandom_range(6, 7)));
      end else if (k < 98) begin
         send_random(CMD_INIT_DONE);
      end else begin
         send_random(CMD_FATAL);
      end
   endtask

   // init, a zeroing run (now and then broken off), then running traffic
   task automatic run_episode(bit idling, int unsigned stop_at);
      int unsigned n_zero;
      int unsigned i;
      bit          broken;
      if (idling) begin
         case ($urandom_range(0, 3))
            0: req_gap_odds = 0;
            1: req_gap_odds = 3;
            default: req_gap_odds = 12;
         endcase
         case ($urandom_range(0, 3))
            0: rsp_stall_odds = 0;
            1: rsp_stall_odds = 3;
            default: rsp_stall_odds = 12;
         endcase
      end
      press_base = $urandom_range(0, 1000000);
      send_random(CMD_INIT_DONE);
      broken = ($urandom_range(0, 5) == 0);
      n_zero = broken ? $urandom_range(0, 40) : LAST_ZERO_SAMPLE_DEF + 1;
      for (i = 0; i < n_zero; i++) begin
         if ($urandom_range(0, 11) == 0)
            send_random($urandom_range(0, 3) == 0 ? CMD_RECAL : CMD_POLL);
         send_random(CMD_SAMPLE);
      end
      if (broken) begin
         case ($urandom_range(0, 2))
            0: send_random(CMD_COMM_FAIL);
            1: send_random(CMD_FATAL);
            default: send_random(CMD_INIT_DONE);
         endcase
      end
      repeat ($urandom_range(10, 120))
         if (sb.events < stop_at)
            send_running_item();
   endtask

   // hand-picked cases under the reset register values
   task automatic directed_checks();
      int i;
      send_event(3'd6, '1, 15'h4000, 1'b1);
      send_event(3'd7, '0, 15'h3FFF, 1'b0);
      // ignored while uninitialized
      send_event(CMD_SAMPLE, '1, 15'h3FFF, 1'b1);
      send_random(CMD_COMM_FAIL);
      send_event(CMD_POLL, '0, '0, 1'b1);
      send_random(CMD_FATAL);
      send_random(CMD_INIT_DONE);
      send_event(CMD_POLL, '0, '0, 1'b0);
      // comm failure during zeroing drops to uninitialized
      send_random(CMD_COMM_FAIL);
      send_random(CMD_INIT_DONE);
      // seed the surface at full scale, then filter it down with zeros
      for (i = 1; i <= LAST_ZERO_SAMPLE_DEF + 1; i++)
         send_event(CMD_SAMPLE, i == DISCARD_SAMPLES_DEF + 1 ? 20'hFFFFF :
                    i > DISCARD_SAMPLES_DEF + 1 ? 20'h0 : rand_pressure(), rand_temp(), 1'b0);
      send_event(CMD_SAMPLE, '0, 15'(-4000), 1'b0);
      send_event(CMD_SAMPLE, '1, 15'(8500), 1'b0);
      send_event(CMD_POLL, '0, '0, 1'b1);
      repeat (4) send_random(CMD_COMM_FAIL);
      send_random(CMD_SAMPLE);
      repeat (4) send_event(CMD_POLL, '0, '0, 1'b0);
      send_random(CMD_RECAL);
      send_event(CMD_POLL, '0, '0, 1'b1);
      send_event(CMD_POLL, '0, '0, 1'b0);
      send_random(CMD_FATAL);
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] fault_set[NUM_PHASES];
      logic [CSR_DATA_W-1:0] scale_set[NUM_PHASES];
      int unsigned           stop_at;
      int                    ph;
      bit                    first;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_we     = 1'b0;
      csr_index  = CSR_FAULT_COUNT;
      csr_wdata  = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      directed_checks();

      // register settings per phase; the last one runs without idling
      fault_set = '{20'd1, 20'd255, 20'd0, 20'd5, 20'd0, 20'd3};
      scale_set = '{20'hFFFFF, 20'd1, 20'd65536, 20'd0, 20'd0, DEPTH_SCALE_RST};
      fault_set[4] = {12'($urandom), 8'($urandom_range(1, 255))};
      scale_set[3] = CSR_DATA_W'($urandom_range(1, 1048575));
      scale_set[4] = CSR_DATA_W'($urandom_range(1, 1048575));

      for (ph = 0; ph < NUM_PHASES; ph++) begin
         hold_until_drained();
         repeat (4) @(posedge clock);
         write_csr(CSR_FAULT_COUNT, fault_set[ph]);
         write_csr(CSR_DEPTH_SCALE, scale_set[ph]);
         if (ph == NUM_PHASES - 1) begin
            req_gap_odds   = 0;
            rsp_stall_odds = 0;
         end
         stop_at = (RANDOM_ITEMS * (ph + 1)) / NUM_PHASES;
         first   = 1'b1;
         while (sb.events < stop_at) begin
            run_episode(ph != NUM_PHASES - 1, stop_at);
            if (first && ph == 1)
               hold_until_drained();
            first = 1'b0;
         end
      end

      hold_until_drained();
      repeat (10) @(posedge clock);
      if (sb.expected_q.size() != 0)
         sb.report_mismatch("results never delivered", sb.expected_q.size(), 0);

      $display("covered %0d events (%0d acted on), %0d results checked, %0d register settings",
               sb.events, sb.useful_events, sb.checked, NUM_PHASES + 1);
      $display("errors predicted: %0d comm, %0d overrun, %0d fatal; %0d readings stored",
               sb.err_seen[ERR_COMM], sb.err_seen[ERR_OVERRUN], sb.err_seen[ERR_FATAL],
               sb.stored);
      if (sb.errors == 0)
         $display("depth_sensor_zero_and_monitor_test: PASS");
      else
         $display("depth_sensor_zero_and_monitor_test: FAIL");
      $finish;
   end

   // watchdog
   initial begin
      #5000000;
      $display("timeout waiting for the block");
      $display("depth_sensor_zero_and_monitor_test: FAIL");
      $finish;
   end

endmodule

@@ depth_sensor_zero_and_monitor.f @@
hw/rtl/dszm_pkg.sv
hw/rtl/dszm_state.sv
hw/rtl/dszm_depth.sv
hw/rtl/depth_sensor_zero_and_monitor.sv
tb/depth_sensor_zero_and_monitor_test.sv
